### hdl/drchs_pkg.sv
// shared types, constants and widths for the disk request to chs command block
// no dependencies; imported by every module of the block
package drchs_pkg;

    localparam int DEVICES_DEF      = 5;
    localparam int BLOCK_BYTES_DEF  = 1024;
    localparam int SECTOR_BYTES_DEF = 512;

    localparam int DEV_W      = 4;
    localparam int COUNT_W    = 16;
    localparam int WORD_W     = 32;
    localparam int HC_W       = 5;
    localparam int SPT_W      = 8;
    localparam int DONE_W     = 11;
    localparam int BYTE_W     = 8;
    localparam int CYL_KEEP_W = 10;
    localparam int HEAD_KEEP_W = 4;

    localparam int S_TDATA_W  = 120;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 64;
    localparam int M_TUSER_W  = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // divider: 32-bit dividend, two quotient bits per cycle
    localparam int DSR_W      = 13;
    localparam int GEO_W      = 13;
    localparam int DIV_STEPS  = WORD_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);
    localparam int HEAD_STEPS = (GEO_W + 1) / 2;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVES     = 2'd2;

    localparam logic [HC_W-1:0]  HC_RST  = 5'd4;
    localparam logic [SPT_W-1:0] SPT_RST = 8'd17;
    localparam logic             DRV_RST = 1'b1;

    localparam logic [BYTE_W-1:0] OP_READ   = 8'h15;
    localparam logic [BYTE_W-1:0] OP_WRITE  = 8'h95;
    localparam logic [BYTE_W-1:0] SIZE_CODE = 8'h02;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IO      = 2'd1,
        ST_INVALID = 2'd2,
        ST_END     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DIV_BLK,
        DIV_SEC,
        DIV_CYL,
        DIV_HEAD
    } div_op_t;

    typedef struct packed {
        logic    capture;
        logic    write_entry;
        logic    div_start;
        div_op_t div_op;
        logic    first_from_a;
        logic    first_from_b;
        logic    lba_load;
        logic    cyl_load;
        logic    chs_load;
        logic    res_load;
        logic    res_ok;
        status_t res_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       dev_bad;
        logic       count_bad;
        logic       no_drive;
        logic       div_busy;
        logic       div_done;
        logic       rem_nonzero;
        logic       past_end;
    } dp_sts_t;

endpackage

### hdl/drchs_div.sv
// iterative restoring divider, two quotient bits per cycle
// depends on drchs_pkg for widths
module drchs_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [drchs_pkg::WORD_W-1:0] dividend,
    input  logic [drchs_pkg::DSR_W-1:0]  divisor,
    input  logic [drchs_pkg::STEP_W-1:0] steps,
    output logic                         busy,
    output logic                         done,
    output logic [drchs_pkg::WORD_W-1:0] quotient,
    output logic [drchs_pkg::DSR_W-1:0]  remainder
);
    import drchs_pkg::*;

    logic [WORD_W-1:0] dvd_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DSR_W:0]    r1;
    logic [DSR_W:0]    r1s;
    logic [DSR_W:0]    r2;
    logic [DSR_W:0]    r2s;
    logic              ge1;
    logic              ge2;
    logic [WORD_W-1:0] dvd_next;
    logic [DSR_W-1:0]  rem_next;

    always_comb begin
        r1       = {rem_reg, dvd_reg[WORD_W-1]};
        ge1      = r1 >= {1'b0, dsr_reg};
        r1s      = ge1 ? (r1 - {1'b0, dsr_reg}) : r1;
        r2       = {r1s[DSR_W-1:0], dvd_reg[WORD_W-2]};
        ge2      = r2 >= {1'b0, dsr_reg};
        r2s      = ge2 ? (r2 - {1'b0, dsr_reg}) : r2;
        dvd_next = {dvd_reg[WORD_W-3:0], ge1, ge2};
        rem_next = r2s[DSR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= steps;
                busy_reg <= (steps != '0);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

### hdl/drchs_dp.sv
// datapath: input capture, geometry registers, partition table, divider and result
// depends on drchs_pkg and drchs_div
module drchs_dp #(
    parameter int DEVICES      = drchs_pkg::DEVICES_DEF,
    parameter int BLOCK_BYTES  = drchs_pkg::BLOCK_BYTES_DEF,
    parameter int SECTOR_BYTES = drchs_pkg::SECTOR_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [drchs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drchs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]                       in_mode,
    input  logic [drchs_pkg::DEV_W-1:0]      in_device,
    input  logic [drchs_pkg::COUNT_W-1:0]    in_byte_count,
    input  logic [drchs_pkg::WORD_W-1:0]     in_byte_offset,
    input  logic [drchs_pkg::WORD_W-1:0]     in_entry_base,
    input  logic [drchs_pkg::WORD_W-1:0]     in_entry_size,
    input  logic                             in_old_style_part,
    input  drchs_pkg::ctl_cmd_t              cmd,
    output drchs_pkg::dp_sts_t               sts,
    output logic [1:0]                       res_status,
    output logic [drchs_pkg::DONE_W-1:0]     res_bytes_done,
    output logic [drchs_pkg::BYTE_W-1:0]     res_cmd_opcode,
    output logic [drchs_pkg::BYTE_W-1:0]     res_cmd_head_cyl_high,
    output logic [drchs_pkg::BYTE_W-1:0]     res_cmd_cyl_low,
    output logic [drchs_pkg::BYTE_W-1:0]     res_cmd_sector,
    output logic [drchs_pkg::BYTE_W-1:0]     res_cmd_size_code,
    output logic [drchs_pkg::BYTE_W-1:0]     res_cmd_sector_count
);
    import drchs_pkg::*;

    localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int BPS   = BLOCK_BYTES / SECTOR_BYTES;
    localparam logic [WORD_W-1:0] BPS_W     = WORD_W'(BPS);
    localparam logic [WORD_W-1:0] BLK_W     = WORD_W'(BLOCK_BYTES);
    localparam logic [DEV_W:0]    DEV_LIM   = (DEV_W + 1)'(DEVICES);
    localparam logic [DSR_W-1:0]  BLK_DSR   = DSR_W'(BLOCK_BYTES);
    localparam logic [DSR_W-1:0]  SEC_DSR   = DSR_W'(SECTOR_BYTES);

    // captured item
    logic [1:0]         mode_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [WORD_W-1:0]  off_reg;
    logic [WORD_W-1:0]  ebase_reg;
    logic [WORD_W-1:0]  esize_reg;
    logic               old_reg;

    // geometry
    logic [HC_W-1:0]    hc_reg;
    logic [SPT_W-1:0]   spt_reg;
    logic               drv_reg;

    logic [WORD_W-1:0]  base_reg [DEVICES];
    logic [WORD_W-1:0]  size_reg [DEVICES];

    logic [WORD_W-1:0]      first_reg;
    logic [WORD_W-1:0]      lba_reg;
    logic [CYL_KEEP_W-1:0]  cyl_reg;
    logic [HEAD_KEEP_W-1:0] head_reg;
    logic [SPT_W-1:0]       sec_reg;

    logic [1:0]        status_reg;
    logic [DONE_W-1:0] done_bytes_reg;
    logic [BYTE_W-1:0] opcode_reg;
    logic [BYTE_W-1:0] hch_reg;
    logic [BYTE_W-1:0] cyl_low_reg;
    logic [BYTE_W-1:0] sector_reg;
    logic [BYTE_W-1:0] size_code_reg;
    logic [BYTE_W-1:0] sec_count_reg;

    logic [IDX_W-1:0]  dev_idx;
    logic              dev_bad;
    logic [WORD_W-1:0] sel_base;
    logic [WORD_W-1:0] sel_size;
    logic [WORD_W-1:0] adj_base;
    logic [WORD_W-1:0] adj_size;
    logic [HC_W-1:0]   hc_eff;
    logic [SPT_W-1:0]  spt_eff;
    logic [GEO_W-1:0]  cyl_size;

    logic [WORD_W-1:0] div_dividend;
    logic [DSR_W-1:0]  div_divisor;
    logic [STEP_W-1:0] div_steps;
    logic              div_busy;
    logic              div_done;
    logic [WORD_W-1:0] div_quot;
    logic [DSR_W-1:0]  div_rem;

    assign dev_idx  = dev_reg[IDX_W-1:0];
    assign dev_bad  = {1'b0, dev_reg} >= DEV_LIM;
    assign sel_base = dev_bad ? '0 : base_reg[dev_idx];
    assign sel_size = dev_bad ? '0 : size_reg[dev_idx];
    assign hc_eff   = (hc_reg == '0) ? HC_W'(1) : hc_reg;
    assign spt_eff  = (spt_reg == '0) ? SPT_W'(1) : spt_reg;
    assign cyl_size = GEO_W'(hc_eff) * GEO_W'(spt_eff);

    // old-style partitions start on an even sector
    always_comb begin
        adj_base = ebase_reg;
        adj_size = esize_reg;
        if (old_reg && ebase_reg[0]) begin
            adj_base = ebase_reg + 1'b1;
            adj_size = esize_reg - 1'b1;
        end
    end

    always_comb begin
        sts.mode        = mode_reg;
        sts.dev_bad     = dev_bad;
        sts.count_bad   = count_reg != BLK_W[COUNT_W-1:0] || BLK_W[WORD_W-1:COUNT_W] != '0;
        sts.no_drive    = !drv_reg;
        sts.div_busy    = div_busy;
        sts.div_done    = div_done;
        sts.rem_nonzero = div_rem != '0;
        sts.past_end    = ({1'b0, first_reg} + {1'b0, BPS_W}) > {1'b0, sel_size};
    end

    always_comb begin
        case (cmd.div_op)
            DIV_BLK: begin
                div_dividend = off_reg;
                div_divisor  = BLK_DSR;
                div_steps    = STEP_W'(DIV_STEPS);
            end
            DIV_SEC: begin
                div_dividend = off_reg;
                div_divisor  = SEC_DSR;
                div_steps    = STEP_W'(DIV_STEPS);
            end
            DIV_CYL: begin
                div_dividend = lba_reg;
                div_divisor  = DSR_W'(cyl_size);
                div_steps    = STEP_W'(DIV_STEPS);
            end
            default: begin
                div_dividend = WORD_W'({1'b0, div_rem[GEO_W-1:0]})
                               << (WORD_W - 2 * HEAD_STEPS);
                div_divisor  = DSR_W'(spt_eff);
                div_steps    = STEP_W'(HEAD_STEPS);
            end
        endcase
    end

    drchs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hc_reg  <= HC_RST;
            spt_reg <= SPT_RST;
            drv_reg <= DRV_RST;
            for (int i = 0; i < DEVICES; i++) begin
                base_reg[i] <= '0;
                size_reg[i] <= '0;
            end
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_HEAD_COUNT: hc_reg  <= cfg_wdata[HC_W-1:0];
                    CFG_SPT:        spt_reg <= cfg_wdata[SPT_W-1:0];
                    CFG_DRIVES:     drv_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.write_entry) begin
                base_reg[dev_idx] <= adj_base;
                size_reg[dev_idx] <= adj_size;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= in_mode;
            dev_reg   <= in_device;
            count_reg <= in_byte_count;
            off_reg   <= in_byte_offset;
            ebase_reg <= in_entry_base;
            esize_reg <= in_entry_size;
            old_reg   <= in_old_style_part;
        end
        if (cmd.first_from_a) begin
            first_reg <= div_quot * BPS_W;
        end
        if (cmd.first_from_b) begin
            first_reg <= div_quot;
        end
        if (cmd.lba_load) begin
            lba_reg <= first_reg + sel_base;
        end
        if (cmd.cyl_load) begin
            cyl_reg <= div_quot[CYL_KEEP_W-1:0];
        end
        if (cmd.chs_load) begin
            head_reg <= div_quot[HEAD_KEEP_W-1:0];
            sec_reg  <= div_rem[SPT_W-1:0] + 1'b1;
        end
        if (cmd.res_load) begin
            status_reg <= cmd.res_status;
            if (cmd.res_ok) begin
                done_bytes_reg <= BLK_W[DONE_W-1:0];
                opcode_reg     <= (mode_reg == MODE_READ) ? OP_READ : OP_WRITE;
                hch_reg        <= {head_reg, 2'b00, cyl_reg[CYL_KEEP_W-1:BYTE_W]};
                cyl_low_reg    <= cyl_reg[BYTE_W-1:0];
                sector_reg     <= sec_reg;
                size_code_reg  <= SIZE_CODE;
                sec_count_reg  <= BPS_W[BYTE_W-1:0];
            end else begin
                done_bytes_reg <= '0;
                opcode_reg     <= '0;
                hch_reg        <= '0;
                cyl_low_reg    <= '0;
                sector_reg     <= '0;
                size_code_reg  <= '0;
                sec_count_reg  <= '0;
            end
        end
    end

    assign res_status            = status_reg;
    assign res_bytes_done        = done_bytes_reg;
    assign res_cmd_opcode        = opcode_reg;
    assign res_cmd_head_cyl_high = hch_reg;
    assign res_cmd_cyl_low       = cyl_low_reg;
    assign res_cmd_sector        = sector_reg;
    assign res_cmd_size_code     = size_code_reg;
    assign res_cmd_sector_count  = sec_count_reg;

endmodule

### hdl/drchs_ctrl.sv
// controller: request checks in order and sequencing of the divisions
// depends on drchs_pkg; drives the datapath through ctl_cmd_t
module drchs_ctrl #(
    parameter int BLOCK_BYTES  = drchs_pkg::BLOCK_BYTES_DEF,
    parameter int SECTOR_BYTES = drchs_pkg::SECTOR_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  drchs_pkg::dp_sts_t  sts,
    output drchs_pkg::ctl_cmd_t cmd
);
    import drchs_pkg::*;

    localparam bit BLOCK_MULT = (BLOCK_BYTES % SECTOR_BYTES) == 0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_A,
        S_DIV_B,
        S_RANGE,
        S_START_C,
        S_DIV_C,
        S_DIV_D,
        S_FINISH
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;
    logic    ok_reg, ok_next;
    logic    tvalid_reg, tvalid_next;

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        ok_next     = ok_reg;
        tvalid_next = tvalid_reg;
        cmd         = '0;
        cmd.div_op     = DIV_BLK;
        cmd.res_ok     = ok_reg;
        cmd.res_status = status_reg;
        s_tready    = 1'b0;

        if (tvalid_reg && m_tready) begin
            tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                ok_next    = 1'b0;
                state_next = S_FINISH;
                unique case (sts.mode)
                    MODE_LOAD: begin
                        if (sts.dev_bad) begin
                            status_next = ST_IO;
                        end else begin
                            cmd.write_entry = 1'b1;
                            status_next     = ST_OK;
                        end
                    end
                    MODE_READ, MODE_WRITE: begin
                        if (sts.dev_bad) begin
                            status_next = ST_IO;
                        end else if (sts.count_bad) begin
                            status_next = ST_INVALID;
                        end else if (sts.no_drive) begin
                            status_next = ST_IO;
                        end else begin
                            cmd.div_start = 1'b1;
                            cmd.div_op    = DIV_BLK;
                            state_next    = S_DIV_A;
                        end
                    end
                    default: begin
                        status_next = ST_INVALID;
                    end
                endcase
            end
            S_DIV_A: begin
                if (sts.div_done) begin
                    if (sts.rem_nonzero) begin
                        status_next = ST_INVALID;
                        state_next  = S_FINISH;
                    end else if (BLOCK_MULT) begin
                        cmd.first_from_a = 1'b1;
                        state_next       = S_RANGE;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_op    = DIV_SEC;
                        state_next    = S_DIV_B;
                    end
                end
            end
            S_DIV_B: begin
                cmd.div_op = DIV_SEC;
                if (sts.div_done) begin
                    cmd.first_from_b = 1'b1;
                    state_next       = S_RANGE;
                end
            end
            S_RANGE: begin
                if (sts.past_end) begin
                    status_next = ST_END;
                    state_next  = S_FINISH;
                end else begin
                    cmd.lba_load = 1'b1;
                    state_next   = S_START_C;
                end
            end
            S_START_C: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_CYL;
                state_next    = S_DIV_C;
            end
            S_DIV_C: begin
                cmd.div_op = DIV_CYL;
                if (sts.div_done) begin
                    cmd.cyl_load  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_HEAD;
                    state_next    = S_DIV_D;
                end
            end
            S_DIV_D: begin
                cmd.div_op = DIV_HEAD;
                if (sts.div_done) begin
                    cmd.chs_load = 1'b1;
                    status_next  = ST_OK;
                    ok_next      = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!tvalid_reg || m_tready) begin
                    cmd.res_load = 1'b1;
                    tvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
            ok_reg     <= 1'b0;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            ok_reg     <= ok_next;
            tvalid_reg <= tvalid_next;
        end
    end

    assign m_tvalid = tvalid_reg;

endmodule

### hdl/disk_request_to_chs_command.sv
// top level of the disk request to chs command block
// depends on drchs_pkg, drchs_ctrl, drchs_dp and drchs_div
//
// s_ channel: one beat per item; s_tuser carries the mode (load entry, read, write)
// m_ channel: one result beat per input beat, status on m_tuser, command bytes on m_tdata
// cfg_ channel: register writes (head count, sectors per track, drives present),
//   always ready, to be used only while no item is in flight
// one item is worked on at a time; s_tready is high only when the controller is idle
// path from input beat to result beat:
//   load items and requests that fail the early checks: capture, checks, result
//   unaligned offset: ends after the block division; past the end: after the range check
//   accepted request: two full passes (block, cylinder) and one short pass (head)
//   of the two-bit-per-cycle divider; one more pass, by the sector size, when the block
//   size is not a whole number of sectors
// a finished result sits in the output register until taken; the next item can be
// accepted meanwhile, and its own result waits for that register to empty
// reset clears the partition table, loads the default geometry and drops m_tvalid
module disk_request_to_chs_command #(
    parameter int DEVICES      = drchs_pkg::DEVICES_DEF,
    parameter int BLOCK_BYTES  = drchs_pkg::BLOCK_BYTES_DEF,
    parameter int SECTOR_BYTES = drchs_pkg::SECTOR_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [drchs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drchs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // device, byte_count, byte_offset, entry_base, entry_size, old_style_part, zero pad
    input  logic [drchs_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic [drchs_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // bytes_done, cmd_opcode, cmd_head_cyl_high, cmd_cyl_low, cmd_sector,
    // cmd_size_code, cmd_sector_count, zero pad
    output logic [drchs_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [drchs_pkg::M_TUSER_W-1:0]  m_tuser
);
    import drchs_pkg::*;

    ctl_cmd_t ctl_cmd;
    dp_sts_t  dp_sts;

    logic [1:0]        res_status;
    logic [DONE_W-1:0] res_bytes_done;
    logic [BYTE_W-1:0] res_cmd_opcode;
    logic [BYTE_W-1:0] res_cmd_head_cyl_high;
    logic [BYTE_W-1:0] res_cmd_cyl_low;
    logic [BYTE_W-1:0] res_cmd_sector;
    logic [BYTE_W-1:0] res_cmd_size_code;
    logic [BYTE_W-1:0] res_cmd_sector_count;

    assign cfg_ready = 1'b1;

    drchs_ctrl #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    drchs_dp #(
        .DEVICES      (DEVICES),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wen               (cfg_valid & cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .in_mode               (s_tuser[1:0]),
        .in_device             (s_tdata[3:0]),
        .in_byte_count         (s_tdata[19:4]),
        .in_byte_offset        (s_tdata[51:20]),
        .in_entry_base         (s_tdata[83:52]),
        .in_entry_size         (s_tdata[115:84]),
        .in_old_style_part     (s_tdata[116]),
        .cmd                   (ctl_cmd),
        .sts                   (dp_sts),
        .res_status            (res_status),
        .res_bytes_done        (res_bytes_done),
        .res_cmd_opcode        (res_cmd_opcode),
        .res_cmd_head_cyl_high (res_cmd_head_cyl_high),
        .res_cmd_cyl_low       (res_cmd_cyl_low),
        .res_cmd_sector        (res_cmd_sector),
        .res_cmd_size_code     (res_cmd_size_code),
        .res_cmd_sector_count  (res_cmd_sector_count)
    );

    assign m_tuser = res_status;
    assign m_tdata = {5'b0, res_cmd_sector_count, res_cmd_size_code, res_cmd_sector,
                      res_cmd_cyl_low, res_cmd_head_cyl_high, res_cmd_opcode,
                      res_bytes_done};

    // a new beat is never taken while the divider still works on the last one
    a_accept_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !dp_sts.div_busy)
        else $error("input beat accepted while divider busy");

    // the divider is only started when free
    a_start_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.div_start |-> !dp_sts.div_busy)
        else $error("divider started while busy");

    // the result register is only loaded when its beat has gone or is leaving
    a_res_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.res_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

    // a table entry is only written for a device that exists
    a_entry_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.write_entry |-> !dp_sts.dev_bad)
        else $error("partition entry written for missing device");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for disk_request_to_chs_command: directed and random beats,
// predicted results compared field by field; needs drchs_pkg and the block's rtl only
module testbench;
    import drchs_pkg::*;

    localparam int N_DEV = DEVICES_DEF;
    localparam int BLK   = BLOCK_BYTES_DEF;
    localparam int SEC   = SECTOR_BYTES_DEF;
    localparam logic [1:0] MODE_BAD = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [1:0]         mode;
        logic [DEV_W-1:0]   device;
        logic [COUNT_W-1:0] byte_count;
        logic [WORD_W-1:0]  byte_offset;
        logic [WORD_W-1:0]  entry_base;
        logic [WORD_W-1:0]  entry_size;
        logic               old_style;
    } disk_req_t;

    typedef struct {
        status_t           status;
        logic [DONE_W-1:0] bytes_done;
        logic [BYTE_W-1:0] opcode;
        logic [BYTE_W-1:0] head_cyl_high;
        logic [BYTE_W-1:0] cyl_low;
        logic [BYTE_W-1:0] sector;
        logic [BYTE_W-1:0] size_code;
        logic [BYTE_W-1:0] sector_count;
    } chs_cmd_t;

    typedef enum {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_RARE} rdy_style_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    // shadow of the block's registers and partition table
    logic [HC_W-1:0]   geo_heads = HC_RST;
    logic [SPT_W-1:0]  geo_spt = SPT_RST;
    logic              geo_drives = DRV_RST;
    logic [WORD_W-1:0] tbl_base [N_DEV] = '{default: '0};
    logic [WORD_W-1:0] tbl_size [N_DEV] = '{default: '0};
    // sizes as loaded, used only to aim random offsets
    logic [WORD_W-1:0] aim_size [N_DEV] = '{default: '0};

    disk_req_t req_queue [$];
    chs_cmd_t  cmd_expected [$];
    disk_req_t cur_req;
    bit        s_beat_taken = 0;
    bit        hold_req = 0;
    int        hold_left = 0;
    int        gap_left = 0;
    int        burst_left = 1;
    int        style_left = 0;
    rdy_style_t rdy_style = RDY_ALWAYS;
    int        cycle_cnt = 0;
    int        err_cnt = 0;
    int        items_in = 0;
    int        settings_cnt = 1;
    int        st_cnt [4] = '{default: 0};

    disk_request_to_chs_command u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic chs_cmd_t chs_predict(input disk_req_t r);
        chs_cmd_t c;
        logic [WORD_W-1:0] base, size, first, lba, h, s, cyl_len, cyl, head, sec;
        c = '{ST_OK, '0, '0, '0, '0, '0, '0, '0};
        if (r.mode == MODE_LOAD) begin
            if (r.device >= N_DEV) begin
                c.status = ST_IO;
            end else begin
                base = r.entry_base;
                size = r.entry_size;
                // old-style partitions start on an even sector
                if (r.old_style && base[0]) begin
                    base = base + 1;
                    size = size - 1;
                end
                tbl_base[r.device] = base;
                tbl_size[r.device] = size;
            end
            return c;
        end
        if (r.mode == MODE_BAD) begin
            c.status = ST_INVALID;
            return c;
        end
        first = r.byte_offset / SEC;
        if (r.device >= N_DEV)
            c.status = ST_IO;
        else if (r.byte_count != BLK)
            c.status = ST_INVALID;
        else if ((32'(r.device) / N_DEV) >= 32'(geo_drives))
            c.status = ST_IO;
        else if (r.byte_offset % BLK != 0)
            c.status = ST_INVALID;
        else if (({1'b0, first} + 33'(BLK / SEC)) > {1'b0, tbl_size[r.device]})
            c.status = ST_END;
        if (c.status != ST_OK)
            return c;
        lba = first + tbl_base[r.device];
        h = (geo_heads == 0) ? 32'd1 : 32'(geo_heads);
        s = (geo_spt == 0) ? 32'd1 : 32'(geo_spt);
        cyl_len = h * s;
        cyl = lba / cyl_len;
        sec = lba % s + 1;
        head = (lba % cyl_len) / s;
        c.bytes_done = DONE_W'(BLK);
        c.opcode = (r.mode == MODE_READ) ? OP_READ : OP_WRITE;
        c.head_cyl_high = {head[3:0], 2'b00, cyl[9:8]};
        c.cyl_low = cyl[7:0];
        c.sector = sec[7:0];
        c.size_code = SIZE_CODE;
        c.sector_count = BYTE_W'(BLK / SEC);
        return c;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // monitor: register writes, accepted input beats and result beats
    always @(posedge aclk) begin
        chs_cmd_t want, got;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end else if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HEAD_COUNT: geo_heads = cfg_wdata[HC_W-1:0];
                    CFG_SPT:        geo_spt = cfg_wdata[SPT_W-1:0];
                    CFG_DRIVES:     geo_drives = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                cmd_expected.push_back(chs_predict(cur_req));
                s_beat_taken = 1;
                items_in++;
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.bytes_done = m_tdata[10:0];
                got.opcode = m_tdata[18:11];
                got.head_cyl_high = m_tdata[26:19];
                got.cyl_low = m_tdata[34:27];
                got.sector = m_tdata[42:35];
                got.size_code = m_tdata[50:43];
                got.sector_count = m_tdata[58:51];
                if (cmd_expected.size() == 0) begin
                    $error("result beat with no request outstanding");
                    err_cnt++;
                end else begin
                    want = cmd_expected.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("bytes_done", 32'(want.bytes_done), 32'(got.bytes_done));
                    check_field("cmd_opcode", 32'(want.opcode), 32'(got.opcode));
                    check_field("cmd_head_cyl_high", 32'(want.head_cyl_high),
                                32'(got.head_cyl_high));
                    check_field("cmd_cyl_low", 32'(want.cyl_low), 32'(got.cyl_low));
                    check_field("cmd_sector", 32'(want.sector), 32'(got.sector));
                    check_field("cmd_size_code", 32'(want.size_code), 32'(got.size_code));
                    check_field("cmd_sector_count", 32'(want.sector_count),
                                32'(got.sector_count));
                    st_cnt[want.status]++;
                end
            end
        end
    end

    // driver: bursts of beats with random gaps
    always @(negedge aclk) begin
        logic nxt;
        nxt = s_tvalid;
        if (aresetn && (!s_tvalid || s_beat_taken)) begin
            s_beat_taken = 0;
            nxt = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_queue.size() > 0) begin
                cur_req = req_queue.pop_front();
                s_tdata <= {3'b000, cur_req.old_style, cur_req.entry_size, cur_req.entry_base,
                            cur_req.byte_offset, cur_req.byte_count, cur_req.device};
                s_tuser <= cur_req.mode;
                nxt = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
                end
            end
        end
        s_tvalid <= nxt;
    end

    // receiver: stall pattern that changes now and then, plus one long hold-off
    always @(negedge aclk) begin
        logic rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
            rdy = 1'b0;
        end else begin
            if (style_left == 0) begin
                rdy_style = rdy_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 400);
            end else begin
                style_left--;
            end
            case (rdy_style)
                RDY_ALWAYS: rdy = 1'b1;
                RDY_HALF:   rdy = ($urandom_range(0, 1) == 1);
                RDY_MOSTLY: rdy = ($urandom_range(0, 9) != 0);
                default:    rdy = ($urandom_range(0, 7) == 0);
            endcase
        end
        m_tready <= rdy;
    end

    task automatic push_item(input logic [1:0] mode, input logic [DEV_W-1:0] dev,
                             input logic [COUNT_W-1:0] count, input logic [WORD_W-1:0] off,
                             input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] size,
                             input logic old);
        disk_req_t r;
        r = '{mode, dev, count, off, base, size, old};
        if (mode == MODE_LOAD && dev < N_DEV)
            aim_size[dev] = size;
        req_queue.push_back(r);
    endtask

    task automatic push_req(input logic [1:0] mode, input logic [DEV_W-1:0] dev,
                            input logic [COUNT_W-1:0] count, input logic [WORD_W-1:0] off);
        push_item(mode, dev, count, off, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic push_load(input logic [DEV_W-1:0] dev, input logic [WORD_W-1:0] base,
                             input logic [WORD_W-1:0] size, input logic old);
        push_item(MODE_LOAD, dev, 16'($urandom), $urandom, base, size, old);
    endtask

    function automatic logic [WORD_W-1:0] pick_size();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 8);
            1: return $urandom_range(2, 5000);
            2: return $urandom;
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 32'h0080_0000);
        endcase
    endfunction

    // aligned request aimed inside the partition, sometimes right at its end
    task automatic push_good();
        logic [DEV_W-1:0]  dev;
        logic [WORD_W-1:0] top, blk;
        dev = $urandom_range(0, N_DEV - 1);
        top = aim_size[dev] >> 1;
        if (top > 32'h003F_FFFF)
            top = 32'h003F_FFFF;
        case ($urandom_range(0, 9))
            0: blk = top;
            1: blk = (top == 0) ? 0 : top - 1;
            default: blk = (top == 0) ? 0 : $urandom_range(0, top - 1);
        endcase
        push_req($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, dev, 16'(BLK), blk << 10);
    endtask

    task automatic wait_idle();
        while (req_queue.size() != 0 || s_tvalid || cmd_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic run_phase(input logic [HC_W-1:0] heads, input logic [SPT_W-1:0] spt,
                             input logic drives, input int n, input bit hold_off);
        int pick;
        wait_idle();
        cfg_write(CFG_HEAD_COUNT, {3'($urandom_range(0, 7)), heads});
        cfg_write(CFG_SPT, spt);
        cfg_write(CFG_DRIVES, {7'($urandom_range(0, 127)), drives});
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_cnt++;
        for (int d = 0; d < N_DEV; d++)
            push_load(d, $urandom, pick_size(), 1'($urandom_range(0, 1)));
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                push_good();
            else if (pick < 88)
                push_load($urandom_range(0, 5), $urandom, pick_size(),
                          1'($urandom_range(0, 1)));
            else if (pick < 96)
                push_item($urandom_range(0, 3), $urandom_range(0, 15), 16'($urandom),
                          $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 98)
                push_req(MODE_READ, $urandom_range(0, N_DEV - 1), 16'($urandom), 0);
            else
                push_req(MODE_WRITE, $urandom_range(0, N_DEV - 1), 16'(BLK),
                         $urandom | 32'h0000_0200);
        end
        if (hold_off)
            hold_req = 1;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, at reset geometry
        push_req(MODE_READ, 0, 16'(BLK), 0);
        push_load(0, 32'h0, 32'h1000, 1'b0);
        push_load(1, 32'h1235, 32'h800, 1'b1);
        push_load(2, 32'hFFFF_FFFF, 32'h0, 1'b1);
        push_load(3, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
        push_load(4, 32'h7, 32'd100, 1'b0);
        push_load(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_load(N_DEV, 32'h10, 32'h10, 1'b0);
        push_req(MODE_READ, 0, 16'(BLK), 0);
        push_req(MODE_WRITE, 0, 16'(BLK), 32'h001F_FC00);
        push_req(MODE_READ, 0, 16'(BLK), 32'h0020_0000);
        push_req(MODE_READ, 9, 16'(BLK), 0);
        push_req(MODE_WRITE, 15, 16'h0, 32'hFFFF_FFFF);
        push_req(MODE_READ, 0, 16'(BLK - 1), 0);
        push_req(MODE_READ, 0, 16'hFFFF, 0);
        push_req(MODE_WRITE, 0, 16'(BLK), 32'h200);
        push_req(MODE_READ, 0, 16'(BLK), 32'hFFFF_FFFF);
        push_req(MODE_READ, 2, 16'(BLK), 32'hFFFF_FC00);
        push_req(MODE_WRITE, 3, 16'(BLK), 32'h0000_4000);
        push_req(MODE_READ, 1, 16'(BLK), 32'h0000_0400);
        push_req(MODE_WRITE, 4, 16'(BLK), 32'h0000_C400);
        push_req(MODE_WRITE, 4, 16'(BLK), 32'h0000_C800);
        push_item(MODE_BAD, 0, 16'(BLK), 0, 0, 0, 1'b0);
        push_item(MODE_BAD, 15, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        run_phase(5'd16, 8'd255, 1'b1, 250, 1'b1);
        run_phase(5'd1, 8'd1, 1'b1, 200, 1'b0);
        run_phase(5'd0, 8'd0, 1'b1, 150, 1'b0);
        run_phase(5'd31, 8'd255, 1'b1, 200, 1'b0);
        run_phase(5'($urandom_range(1, 16)), 8'($urandom_range(1, 255)), 1'b0, 100, 1'b0);
        run_phase(HC_RST, SPT_RST, DRV_RST, 200, 1'b0);
        for (int p = 0; p < 3; p++)
            run_phase(5'($urandom_range(1, 16)), 8'($urandom_range(1, 255)), 1'b1, 100, 1'b0);
        wait_idle();

        $display("%0d beats over %0d geometry settings; results: %0d ok, %0d io error,",
                 items_in, settings_cnt, st_cnt[ST_OK], st_cnt[ST_IO]);
        $display("%0d invalid, %0d end of device; %0d mismatches",
                 st_cnt[ST_INVALID], st_cnt[ST_END], err_cnt);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
